FILE: rtl/lz77td_pkg.sv
// ----------------------------------------------------------------------------
// lz77td_pkg
// shared constants, types and helpers of the lz77 triplet decoder
// ----------------------------------------------------------------------------
package lz77td_pkg;

  localparam int HISTORY_DEPTH   = 4096;
  localparam int MAX_OFFSET_BITS = 12;
  localparam int MAX_LENGTH_BITS = 5;
  localparam int SYMBOL_BITS     = 8;
  localparam int ADDR_W          = $clog2(HISTORY_DEPTH);
  localparam int ACC_W           = MAX_OFFSET_BITS + MAX_LENGTH_BITS + SYMBOL_BITS;
  localparam int CNT_W           = $clog2(ACC_W + 1);

  // config register fields
  localparam int OB_CFG_W = 4;
  localparam int LB_CFG_W = 3;
  localparam int CFG_W    = 4;

  localparam logic [SYMBOL_BITS-1:0] END_SYMBOL = 8'd3;

  typedef enum logic {
    REG_OFFSET_BITS = 1'b0,
    REG_LENGTH_BITS = 1'b1
  } reg_index_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SHIFT,
    ST_READ,
    ST_COPY,
    ST_LITERAL
  } lz_state_t;

  typedef struct packed {
    logic load;
    logic shift;
    logic read;
    logic copy;
    logic literal;
  } lz_cmd_t;

  typedef struct packed {
    logic trip_done;
    logic new_len_zero;
    logic rem_last;
    logic rem_zero;
    logic copy_last;
    logic is_end;
    logic len_zero;
    logic out_free;
    logic ended;
  } lz_status_t;

endpackage

FILE: rtl/lz77td_if.sv
// ----------------------------------------------------------------------------
// lz77td channel interfaces
// valid/ready channels for packed input bytes and decoded result bytes
// ----------------------------------------------------------------------------
interface lz77td_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] packed_byte;

  modport source (output valid, output packed_byte, input ready);
  modport sink   (input valid, input packed_byte, output ready);
endinterface

interface lz77td_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       byte_valid;
  logic       last;
  logic       stream_end;

  modport source (output valid, output data_byte, output byte_valid, output last,
                  output stream_end, input ready);
  modport sink   (input valid, input data_byte, input byte_valid, input last,
                  input stream_end, output ready);
endinterface

FILE: rtl/lz77_triplet_decoder.sv
// ----------------------------------------------------------------------------
// lz77_triplet_decoder
// lz77 triplet decoder with a 4096-byte history ring
// ----------------------------------------------------------------------------
// Packed bytes enter on feed and are shifted in msb first, one bit per cycle
// while no triplet is being written out. Every offset_bits + length_bits + 8
// bits form a triplet (offset, length, symbol). The block then copies length
// bytes from offset back in the history ring, one transfer on result per byte,
// followed by the symbol as a literal with last set. A symbol of 3 ends the
// stream: the copied bytes go out (the final one with last and stream_end), no
// literal follows, a zero-length end gives one result with byte_valid low, and
// every later byte is taken and dropped until reset. Each copied byte takes a
// history read step and then a copy step, because the single-port history read
// is registered and must see the previous copy's write so that overlapping
// copies repeat bytes correctly. Stalls on result hold the copy sequence.
// Config registers (index 0 offset_bits, index 1 length_bits) are written on
// wr_en and must only change while the block is idle; out of range widths are
// clamped. Copies must only reach bytes already written.
// ----------------------------------------------------------------------------
module lz77_triplet_decoder (
  input  logic                          clk,
  input  logic                          rst,
  lz77td_in_if.sink                     feed,
  lz77td_out_if.source                  result,
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [lz77td_pkg::CFG_W-1:0]  wr_data
);
  import lz77td_pkg::*;

  lz_cmd_t    cmd;
  lz_status_t status;

  // sequencer: owns the input handshake and the step order
  lz77td_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (feed.valid),
    .in_ready (feed.ready),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath: accumulator, history ring and the result register
  lz77td_dp u_dp (
    .clk            (clk),
    .rst            (rst),
    .wr_en          (wr_en),
    .wr_index       (wr_index),
    .wr_data        (wr_data),
    .in_byte        (feed.packed_byte),
    .cmd            (cmd),
    .status         (status),
    .out_valid      (result.valid),
    .out_ready      (result.ready),
    .out_data_byte  (result.data_byte),
    .out_byte_valid (result.byte_valid),
    .out_last       (result.last),
    .out_stream_end (result.stream_end)
  );

endmodule

FILE: rtl/lz77td_ctrl.sv
// ----------------------------------------------------------------------------
// lz77td_ctrl
// sequencer: bit shifting, copy read/write steps and literal emission
// ----------------------------------------------------------------------------
module lz77td_ctrl (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lz77td_pkg::lz_status_t status,
  output lz77td_pkg::lz_cmd_t    cmd
);
  import lz77td_pkg::*;

  lz_state_t state;
  lz_state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid && !status.ended) state_next = ST_SHIFT;
      end
      ST_SHIFT: begin
        if (status.trip_done) begin
          state_next = status.new_len_zero ? ST_LITERAL : ST_READ;
        end else if (status.rem_last) begin
          state_next = ST_IDLE;
        end
      end
      ST_READ: begin
        state_next = ST_COPY;
      end
      ST_COPY: begin
        if (status.out_free) state_next = status.copy_last ? ST_LITERAL : ST_READ;
      end
      ST_LITERAL: begin
        if (status.out_free || (status.is_end && !status.len_zero)) begin
          state_next = (status.is_end || status.rem_zero) ? ST_IDLE : ST_SHIFT;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // commands
  always_comb begin
    cmd      = '0;
    in_ready = 1'b0;
    case (state)
      ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid && !status.ended;
      end
      ST_SHIFT:   cmd.shift = 1'b1;
      ST_READ:    cmd.read  = 1'b1;
      ST_COPY:    cmd.copy  = status.out_free;
      ST_LITERAL: cmd.literal = status.out_free || (status.is_end && !status.len_zero);
      default:    cmd = '0;
    endcase
  end

endmodule

FILE: rtl/lz77td_dp.sv
// ----------------------------------------------------------------------------
// lz77td_dp
// datapath: config, bit accumulator, field decode, history ring, result register
// ----------------------------------------------------------------------------
module lz77td_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          wr_en,
  input  logic                          wr_index,
  input  logic [lz77td_pkg::CFG_W-1:0]  wr_data,
  input  logic [7:0]                    in_byte,
  input  lz77td_pkg::lz_cmd_t           cmd,
  output lz77td_pkg::lz_status_t        status,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic [7:0]                    out_data_byte,
  output logic                          out_byte_valid,
  output logic                          out_last,
  output logic                          out_stream_end
);
  import lz77td_pkg::*;

  // config registers
  logic [OB_CFG_W-1:0] offset_bits;
  logic [LB_CFG_W-1:0] length_bits;

  // bit gathering
  logic [7:0]       byte_sr;
  logic [3:0]       rem;
  logic [ACC_W-1:0] acc;
  logic [CNT_W-1:0] bit_count;

  // current triplet
  logic [MAX_OFFSET_BITS-1:0] offset;
  logic [MAX_LENGTH_BITS-1:0] len;
  logic [MAX_LENGTH_BITS-1:0] copy_cnt;
  logic [SYMBOL_BITS-1:0]     sym;
  logic                       is_end;
  logic                       ended;

  // history ring
  logic [7:0]        mem [HISTORY_DEPTH];
  logic [ADDR_W-1:0] wp;
  logic [ADDR_W-1:0] rd_addr;
  logic [7:0]        rd_data;
  logic              mem_we;
  logic [7:0]        mem_wdata;

  logic [OB_CFG_W-1:0] ob;
  logic [LB_CFG_W-1:0] lb;
  logic [CNT_W-1:0]    width;
  logic [ACC_W-1:0]    acc_next;
  logic [CNT_W-1:0]    count_inc;
  logic [ACC_W-1:0]    len_full;
  logic [ACC_W-1:0]    off_full;
  logic                trip_done;
  logic                out_load;
  logic [7:0]          res_data;
  logic                res_valid;
  logic                res_last;
  logic                res_end;
  logic                copy_fin;

  // clamp widths into their legal ranges
  always_comb begin
    if (offset_bits == '0) ob = OB_CFG_W'(1);
    else if (offset_bits > OB_CFG_W'(MAX_OFFSET_BITS)) ob = OB_CFG_W'(MAX_OFFSET_BITS);
    else ob = offset_bits;
    if (length_bits == '0) lb = LB_CFG_W'(1);
    else if (length_bits > LB_CFG_W'(MAX_LENGTH_BITS)) lb = LB_CFG_W'(MAX_LENGTH_BITS);
    else lb = length_bits;
  end

  assign width     = CNT_W'(ob) + CNT_W'(lb) + CNT_W'(SYMBOL_BITS);
  assign acc_next  = {acc[ACC_W-2:0], byte_sr[7]};
  assign count_inc = (bit_count < CNT_W'(ACC_W)) ? bit_count + CNT_W'(1) : bit_count;
  assign trip_done = count_inc >= width;

  // field extraction from the freshly shifted accumulator
  assign len_full = (acc_next >> SYMBOL_BITS) & ((ACC_W'(1) << lb) - ACC_W'(1));
  assign off_full = (acc_next >> (CNT_W'(lb) + CNT_W'(SYMBOL_BITS)))
                    & ((ACC_W'(1) << ob) - ACC_W'(1));

  assign rd_addr  = wp - ADDR_W'(offset);
  assign copy_fin = is_end && (copy_cnt == MAX_LENGTH_BITS'(1));

  always_comb begin
    mem_we    = 1'b0;
    mem_wdata = rd_data;
    out_load  = 1'b0;
    res_data  = rd_data;
    res_valid = 1'b1;
    res_last  = copy_fin;
    res_end   = copy_fin;
    if (cmd.copy) begin
      mem_we   = 1'b1;
      out_load = 1'b1;
    end else if (cmd.literal) begin
      if (!is_end) begin
        mem_we    = 1'b1;
        mem_wdata = sym;
        out_load  = 1'b1;
        res_data  = sym;
        res_last  = 1'b1;
        res_end   = 1'b0;
      end else if (len == '0) begin
        out_load  = 1'b1;
        res_data  = 8'd0;
        res_valid = 1'b0;
        res_last  = 1'b1;
        res_end   = 1'b1;
      end
    end
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      offset_bits <= OB_CFG_W'(MAX_OFFSET_BITS);
      length_bits <= LB_CFG_W'(MAX_LENGTH_BITS);
      rem         <= '0;
      acc         <= '0;
      bit_count   <= '0;
      wp          <= '0;
      ended       <= 1'b0;
      out_valid   <= 1'b0;
    end else begin
      if (wr_en) begin
        case (reg_index_t'(wr_index))
          REG_OFFSET_BITS: offset_bits <= wr_data[OB_CFG_W-1:0];
          REG_LENGTH_BITS: length_bits <= wr_data[LB_CFG_W-1:0];
          default: ;
        endcase
      end
      if (cmd.load) rem <= 4'd8;
      if (cmd.shift) begin
        rem <= rem - 4'd1;
        if (trip_done) begin
          acc       <= '0;
          bit_count <= '0;
        end else begin
          acc       <= acc_next;
          bit_count <= count_inc;
        end
      end
      if (mem_we) wp <= wp + ADDR_W'(1);
      if (cmd.literal && is_end) ended <= 1'b1;
      if (out_load) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.load) byte_sr <= in_byte;
    else if (cmd.shift) byte_sr <= {byte_sr[6:0], 1'b0};
    if (cmd.shift && trip_done) begin
      offset   <= off_full[MAX_OFFSET_BITS-1:0];
      len      <= len_full[MAX_LENGTH_BITS-1:0];
      copy_cnt <= len_full[MAX_LENGTH_BITS-1:0];
      sym      <= acc_next[SYMBOL_BITS-1:0];
      is_end   <= acc_next[SYMBOL_BITS-1:0] == END_SYMBOL;
    end else if (cmd.copy) begin
      copy_cnt <= copy_cnt - MAX_LENGTH_BITS'(1);
    end
    if (out_load) begin
      out_data_byte  <= res_data;
      out_byte_valid <= res_valid;
      out_last       <= res_last;
      out_stream_end <= res_end;
    end
  end

  // history ring, registered read
  always_ff @(posedge clk) begin
    if (mem_we) mem[wp] <= mem_wdata;
    if (cmd.read) rd_data <= mem[rd_addr];
  end

  always_comb begin
    status.trip_done    = trip_done;
    status.new_len_zero = len_full[MAX_LENGTH_BITS-1:0] == '0;
    status.rem_last     = rem == 4'd1;
    status.rem_zero     = rem == 4'd0;
    status.copy_last    = copy_cnt == MAX_LENGTH_BITS'(1);
    status.is_end       = is_end;
    status.len_zero     = len == '0;
    status.out_free     = !out_valid || out_ready;
    status.ended        = ended;
  end

endmodule

FILE: test/tb.sv
// ----------------------------------------------------------------------------
// tb: lz77 triplet decoder testbench
// builds packed triplet streams under changing field widths, feeds them with
// random gaps, predicts every decoded byte and checks the results in order
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import lz77td_pkg::*;

  // one decoded result as seen on the result channel
  typedef struct packed {
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;
    logic       stream_end;
  } byte_result_t;

  // predictor of the decoder plus the queue of bytes it still owes us
  class triplet_scoreboard;
    logic [7:0]          ring [HISTORY_DEPTH];
    logic [ADDR_W-1:0]   wptr;
    logic [ACC_W-1:0]    shift_acc;
    int unsigned         shift_cnt;
    bit                  stopped;
    logic [OB_CFG_W-1:0] cfg_ob;
    logic [LB_CFG_W-1:0] cfg_lb;
    byte_result_t        due_bytes[$];
    int unsigned         errors;
    int unsigned         checked;

    function new();
      wptr      = '0;
      shift_acc = '0;
      shift_cnt = 0;
      stopped   = 1'b0;
      cfg_ob    = OB_CFG_W'(MAX_OFFSET_BITS);
      cfg_lb    = LB_CFG_W'(MAX_LENGTH_BITS);
      errors    = 0;
      checked   = 0;
    endfunction

    // zero counts as one, anything past the top is the top
    static function int unsigned fit_width(int unsigned raw, int unsigned top);
      if (raw == 0) return 1;
      return (raw > top) ? top : raw;
    endfunction

    function void set_reg(reg_index_t idx, logic [CFG_W-1:0] val);
      if (idx == REG_OFFSET_BITS) cfg_ob = val[OB_CFG_W-1:0];
      else cfg_lb = val[LB_CFG_W-1:0];
    endfunction

    function int unsigned pending();
      return due_bytes.size();
    endfunction

    // queue one expected result at the tail
    function void owe(byte_result_t r);
      due_bytes.insert(due_bytes.size(), r);
    endfunction

    // copy len bytes from off back, byte by byte, then the literal (none for the end symbol)
    function void expand(logic [31:0] trip, int unsigned ob, int unsigned lb);
      int unsigned off;
      int unsigned len;
      logic [7:0]  sym;
      logic [7:0]  b;
      bit          fin;
      off = (trip >> (lb + SYMBOL_BITS)) & ((32'd1 << ob) - 32'd1);
      len = (trip >> SYMBOL_BITS) & ((32'd1 << lb) - 32'd1);
      sym = trip[7:0];
      for (int unsigned j = 0; j < len; j++) begin
        b = ring[wptr - off[ADDR_W-1:0]];
        ring[wptr] = b;
        wptr++;
        fin = (sym == END_SYMBOL) && (j + 1 == len);
        owe({b, 1'b1, fin, fin});
      end
      if (sym == END_SYMBOL) begin
        stopped = 1'b1;
        if (len == 0) owe({8'h00, 1'b0, 1'b1, 1'b1});
      end else begin
        ring[wptr] = sym;
        wptr++;
        owe({sym, 1'b1, 1'b1, 1'b0});
      end
    endfunction

    // shift one packed byte in, msb first
    function void take_packed(logic [7:0] b);
      int unsigned ob;
      int unsigned lb;
      int unsigned w;
      logic [31:0] m;
      ob = fit_width(cfg_ob, MAX_OFFSET_BITS);
      lb = fit_width(cfg_lb, MAX_LENGTH_BITS);
      w  = ob + lb + SYMBOL_BITS;
      m  = (32'd1 << w) - 32'd1;
      for (int i = 7; i >= 0; i--) begin
        if (stopped) break;
        shift_acc = {shift_acc[ACC_W-2:0], b[i]};
        if (shift_cnt < ACC_W) shift_cnt++;
        if (shift_cnt >= w) begin
          expand(32'(shift_acc) & m, ob, lb);
          shift_acc = '0;
          shift_cnt = 0;
        end
      end
    endfunction

    task report(string what);
      errors++;
      if (errors <= 100) $display("mismatch: %s", what);
    endtask

    task check_byte(byte_result_t got);
      byte_result_t want;
      checked++;
      if (due_bytes.size() == 0) begin
        report($sformatf("result %0d: nothing expected, got data_byte %02h",
                         checked, got.data_byte));
        return;
      end
      want = due_bytes.pop_front();
      if (got.data_byte !== want.data_byte)
        report($sformatf("result %0d: data_byte %02h, expected %02h",
                         checked, got.data_byte, want.data_byte));
      if (got.byte_valid !== want.byte_valid)
        report($sformatf("result %0d: byte_valid %b, expected %b",
                         checked, got.byte_valid, want.byte_valid));
      if (got.last !== want.last)
        report($sformatf("result %0d: last %b, expected %b", checked, got.last, want.last));
      if (got.stream_end !== want.stream_end)
        report($sformatf("result %0d: stream_end %b, expected %b",
                         checked, got.stream_end, want.stream_end));
    endtask
  endclass

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             wr_en;
  reg_index_t       wr_index;
  logic [CFG_W-1:0] wr_data;

  lz77td_in_if  feed();
  lz77td_out_if result();

  lz77_triplet_decoder dut (
    .clk      (clk),
    .rst      (rst),
    .feed     (feed),
    .result   (result),
    .wr_en    (wr_en),
    .wr_index (wr_index),
    .wr_data  (wr_data)
  );

  triplet_scoreboard sb = new();

  // stream builder: bits not yet packed into a byte, and the widths that
  // the triplets being built will be decoded with
  bit               stream_q[$];
  int unsigned      gen_ob;
  int unsigned      gen_lb;
  // ring bytes written once every planned triplet has been decoded, and packed bytes sent
  int unsigned      planned;
  int unsigned      items;
  // width change waiting for the block to go idle
  bit               cfg_due;
  int unsigned      old_tail;
  logic [CFG_W-1:0] next_ob;
  logic [CFG_W-1:0] next_lb;
  // gap modes of the two sides
  bit               tx_busy;
  bit               rx_busy;
  int unsigned      rx_wait;
  int unsigned      rx_draw;
  int unsigned      end_off;
  int unsigned      end_len;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  // one packed byte transfer, after a random hold-off
  task automatic send_byte(logic [7:0] b);
    int unsigned gap;
    gap = tx_busy ? $urandom_range(0, 15) : 0;
    if (gap != 0) begin
      feed.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    feed.valid       <= 1'b1;
    feed.packed_byte <= b;
    do @(posedge clk); while (!feed.ready);
    sb.take_packed(b);
  endtask

  // all results in, then room for a byte that is still being shifted
  task automatic wait_idle();
    feed.valid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (24) @(posedge clk);
  endtask

  task automatic apply_setting();
    wait_idle();
    wr_en    <= 1'b1;
    wr_index <= REG_OFFSET_BITS;
    wr_data  <= next_ob;
    @(posedge clk);
    sb.set_reg(REG_OFFSET_BITS, next_ob);
    wr_index <= REG_LENGTH_BITS;
    wr_data  <= next_lb;
    @(posedge clk);
    sb.set_reg(REG_LENGTH_BITS, next_lb);
    wr_en   <= 1'b0;
    cfg_due = 1'b0;
  endtask

  // send every full byte; a pending width change goes in right after the
  // byte that holds the last bits of the previous setting, so the block
  // keeps the head of the next triplet across the change
  task automatic drain();
    logic [7:0] b;
    while (stream_q.size() >= 8) begin
      if (cfg_due && old_tail == 0) apply_setting();
      for (int i = 7; i >= 0; i--) b[i] = stream_q.pop_front();
      send_byte(b);
      items++;
      old_tail = 0;
    end
  endtask

  function automatic void push_field(int unsigned value, int unsigned n);
    for (int i = n - 1; i >= 0; i--) stream_q.insert(stream_q.size(), value[i]);
  endfunction

  task automatic plan_triplet(int unsigned off, int unsigned len, logic [7:0] sym);
    push_field(off, gen_ob);
    push_field(len, gen_lb);
    push_field(sym, SYMBOL_BITS);
    planned += (sym == END_SYMBOL) ? len : len + 1;
    drain();
  endtask

  // new widths for the triplets built from here on
  task automatic retarget(logic [CFG_W-1:0] ob_raw, logic [CFG_W-1:0] lb_raw);
    next_ob  = ob_raw;
    next_lb  = lb_raw;
    gen_ob   = triplet_scoreboard::fit_width(ob_raw, MAX_OFFSET_BITS);
    gen_lb   = triplet_scoreboard::fit_width(lb_raw[LB_CFG_W-1:0], MAX_LENGTH_BITS);
    cfg_due  = 1'b1;
    old_tail = stream_q.size();
    tx_busy  = $urandom_range(0, 3) != 0;
    rx_busy  = $urandom_range(0, 3) != 0;
  endtask

  // copies only reach bytes already written; offset 0 only with nothing to copy or on a full ring
  task automatic plan_random_triplet(bit long_copy);
    int unsigned top_off;
    int unsigned top_len;
    int unsigned reach;
    int unsigned off;
    int unsigned len;
    logic [7:0]  sym;
    top_off = (1 << gen_ob) - 1;
    top_len = (1 << gen_lb) - 1;
    len = long_copy ? top_len : $urandom_range(0, top_len);
    if (planned == 0) len = 0;
    reach = (planned < top_off) ? planned : top_off;
    if (len == 0 || planned >= HISTORY_DEPTH) off = $urandom_range(0, top_off);
    else if ($urandom_range(0, 1) == 1) off = $urandom_range(1, (reach < 4) ? reach : 4);
    else off = $urandom_range(1, reach);
    do sym = 8'($urandom); while (sym == END_SYMBOL);
    plan_triplet(off, len, sym);
  endtask

  task automatic random_phase();
    int unsigned n;
    n = $urandom_range(2, 8);
    retarget(4'($urandom_range(0, 15)), 4'($urandom_range(0, 15)));
    repeat (n) plan_random_triplet(1'b0);
  endtask

  // result side: a random stall after every transfer, counted down whether
  // or not a result is waiting
  always @(posedge clk) begin
    if (rst) begin
      result.ready <= 1'b0;
      rx_wait      <= 0;
    end else if (result.valid && result.ready) begin
      sb.check_byte({result.data_byte, result.byte_valid, result.last, result.stream_end});
      rx_draw = rx_busy ? $urandom_range(0, 15) : 0;
      if (rx_draw != 0) begin
        result.ready <= 1'b0;
        rx_wait      <= rx_draw;
      end
    end else if (!result.ready) begin
      if (rx_wait <= 1) result.ready <= 1'b1;
      if (rx_wait != 0) rx_wait <= rx_wait - 1;
    end
  end

  initial begin
    feed.valid       <= 1'b0;
    feed.packed_byte <= 8'h00;
    wr_en            <= 1'b0;
    wr_index         <= REG_OFFSET_BITS;
    wr_data          <= '0;
    gen_ob   = MAX_OFFSET_BITS;
    gen_lb   = MAX_LENGTH_BITS;
    planned  = 0;
    items    = 0;
    cfg_due  = 1'b0;
    old_tail = 0;
    tx_busy  = 1'b1;
    rx_busy  = 1'b1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // reset widths: 12-bit offset, 5-bit length
    plan_triplet(0, 0, 8'h00);       // all-zero bytes, offset 0 with nothing to copy
    plan_triplet(1, 5, 8'h41);       // overlapping copy repeats the last byte
    plan_triplet(2, 3, 8'h80);
    // both widths out of range: offset 0 acts as 1, length 7 as 5
    retarget(4'd0, 4'd7);
    plan_triplet(1, 31, 8'hff);      // all-ones bytes, longest copy
    plan_triplet(1, 0, 8'h7e);
    // offset 15 acts as 12, length 0 acts as 1
    retarget(4'd15, 4'd0);
    plan_triplet(planned, 1, 8'h01); // reach back to the very first byte
    plan_triplet(1, 1, 8'hfe);
    retarget(4'd4, 4'd3);
    repeat (3) plan_random_triplet(1'b0);

    // random settings with copies inside the written part of the ring
    while (items < 55) random_phase();

    // long copies, many results per packed byte
    retarget(4'd2, 4'd5);
    while (items < 80) plan_random_triplet(1'b1);

    // more random settings over the grown ring
    while (items < 110) random_phase();

    // end marker, with or without a copy in front of it
    retarget(4'($urandom_range(1, 15)), 4'($urandom_range(1, 7)));
    plan_random_triplet(1'b0);
    end_len = ($urandom_range(0, 1) == 1) ? 0 : $urandom_range(1, (1 << gen_lb) - 1);
    if (end_len == 0) end_off = $urandom_range(0, (1 << gen_ob) - 1);
    else end_off = $urandom_range(1, (planned < (1 << gen_ob) - 1) ?
                                     planned : (1 << gen_ob) - 1);
    plan_triplet(end_off, end_len, END_SYMBOL);
    // rest of the byte and a few more bytes must all be dropped
    while (stream_q.size() % 8 != 0) stream_q.insert(stream_q.size(), 1'($urandom));
    drain();
    repeat (3) send_byte(8'($urandom));

    wait_idle();
    repeat (40) @(posedge clk);
    if (sb.errors == 0) $display("status: pass");
    else $display("status: fail");
    $finish;
  end

  // run limit, far beyond the slowest legal run
  initial begin
    #50_000_000;
    $display("status: fail");
    $finish;
  end

endmodule
